@@ sv/fdia_pkg.sv @@
// Shared types and constants for the fence-deferred index allocator.
package fdia_pkg;
   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_INIT  = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_IGNORED = 2'd1;
   localparam logic [1:0] ST_EXHAUST = 2'd2;
   localparam logic [1:0] ST_DROPPED = 2'd3;

   localparam int CNT_W  = 11;
   localparam int IDX_W  = 10;
   localparam int GROW_W = 4;

   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
   localparam logic [GROW_W-1:0] GROW_MAX = '1;

   localparam logic [0:0] REG_INIT_CAP = 1'b0;
   localparam logic [0:0] REG_MAX_CAP  = 1'b1;

   localparam logic [CNT_W-1:0] INIT_CAP_RESET = 11'd64;
   localparam logic [CNT_W-1:0] MAX_CAP_RESET  = 11'd1024;
endpackage

@@ sv/fdia_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module fdia_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ sv/fence_deferred_index_allocator_unit.sv @@
// Top level of the fence-deferred index allocator: sequencer, counters and CSRs.
//
//  channel   ports                                   handshake
//  request   req_cmd, req_free_index, req_*_fence    start & !busy
//  result    rsp_* fields                            rsp_valid, one cycle
//  config    csr_ APB port                           psel&penable&pwrite
//
// Free and initialize: the sequencer goes from S_IDLE straight to S_DONE, which registers rsp_valid.
// Allocate: S_RD and S_CMP alternate once per pending entry, then S_RD, S_POP_RD, S_POP and
// S_DONE follow; the reclaim walks the pending list one entry at a time through the shared
// read address of the two pending RAMs.
// Reset restores the state, CSR and counter registers and empties both lists at once (fill counts).
// busy is high from the cycle after start and drops in the result beat; results cannot be held.
module fence_deferred_index_allocator_unit #(
   parameter int STORE_DEPTH = 1024,
   parameter int FENCE_BITS  = 48
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_cmd,
   input  logic [fdia_pkg::IDX_W-1:0]       req_free_index,
   input  logic [FENCE_BITS-1:0]            req_submitted_fence,
   input  logic [FENCE_BITS-1:0]            req_completed_fence,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_status,
   output logic [fdia_pkg::IDX_W-1:0]       rsp_alloc_index,
   output logic                             rsp_grew,
   output logic [fdia_pkg::CNT_W-1:0]       rsp_capacity_now,
   output logic [fdia_pkg::CNT_W-1:0]       rsp_live_count,
   output logic [fdia_pkg::CNT_W-1:0]       rsp_peak_live,
   output logic [fdia_pkg::CNT_W-1:0]       rsp_ready_count,
   output logic [fdia_pkg::CNT_W-1:0]       rsp_pending_count,
   output logic [fdia_pkg::GROW_W-1:0]      rsp_growth_count,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [2:0]                       paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import fdia_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int PW = AW + 1;   // counts up to STORE_DEPTH
   localparam logic [PW-1:0] DEPTH_C = PW'(STORE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_CMP, S_POP_RD, S_POP, S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]      icap_ff, icap_in, mcap_ff, mcap_in;
   logic [CNT_W-1:0]      cap_ff, cap_in, live_ff, live_in, peak_ff, peak_in;
   logic [GROW_W-1:0]     grow_ff, grow_in;
   logic [PW-1:0]         top_ff, top_in, fill_ff, fill_in, cur_ff, cur_in;
   logic [PW-1:0]         scan_ff, scan_in, keep_ff, keep_in;
   logic [1:0]            cmd_ff, cmd_in;
   logic [IDX_W-1:0]      fidx_ff, fidx_in;
   logic [FENCE_BITS-1:0] sub_ff, sub_in, done_ff, done_in;
   logic                  valid_ff, valid_in;
   logic [1:0]            stat_ff, stat_in;
   logic [IDX_W-1:0]      aidx_ff, aidx_in;
   logic                  grew_ff, grew_in;

   // RAM ports
   logic                  rs_we, pi_we;
   logic [AW-1:0]         rs_wa, rs_ra, pi_wa, pi_ra;
   logic [IDX_W-1:0]      rs_wd, rs_rd, pi_wd, pi_rd;
   logic [FENCE_BITS-1:0] ps_wd, ps_rd;

   fdia_ram #(.WIDTH(IDX_W), .DEPTH(STORE_DEPTH)) u_ready (
      .clock, .wr_en(rs_we), .wr_addr(rs_wa), .wr_data(rs_wd),
      .rd_addr(rs_ra), .rd_data(rs_rd));
   fdia_ram #(.WIDTH(IDX_W), .DEPTH(STORE_DEPTH)) u_pidx (
      .clock, .wr_en(pi_we), .wr_addr(pi_wa), .wr_data(pi_wd),
      .rd_addr(pi_ra), .rd_data(pi_rd));
   fdia_ram #(.WIDTH(FENCE_BITS), .DEPTH(STORE_DEPTH)) u_pstamp (
      .clock, .wr_en(pi_we), .wr_addr(pi_wa), .wr_data(ps_wd),
      .rd_addr(pi_ra), .rd_data(ps_rd));

   logic csr_wr;
   logic [CNT_W-1:0] eff_max, eff_init, init_nz;
   assign csr_wr = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      eff_max = (mcap_ff == '0) ? CNT_W'(1) : mcap_ff;
      if ({{(PW > CNT_W ? PW-CNT_W : 0){1'b0}}, eff_max} > PW'(STORE_DEPTH)
          && PW >= CNT_W)
         eff_max = CNT_W'(STORE_DEPTH);
      else if (PW < CNT_W && eff_max > CNT_W'(STORE_DEPTH))
         eff_max = CNT_W'(STORE_DEPTH);
      init_nz  = (icap_ff == '0) ? CNT_W'(1) : icap_ff;
      eff_init = (init_nz < eff_max) ? init_nz : eff_max;
   end

   always_comb begin
      unique case (paddr[2])
         REG_INIT_CAP: prdata = {{(32-CNT_W){1'b0}}, icap_ff};
         REG_MAX_CAP:  prdata = {{(32-CNT_W){1'b0}}, mcap_ff};
         default:      prdata = '0;
      endcase
   end

   logic [CNT_W-1:0] cur_c;
   assign cur_c = CNT_W'(cur_ff);

   always_comb begin
      state_in = state_ff;
      icap_in = icap_ff; mcap_in = mcap_ff;
      cap_in = cap_ff; live_in = live_ff; peak_in = peak_ff; grow_in = grow_ff;
      top_in = top_ff; fill_in = fill_ff; cur_in = cur_ff;
      scan_in = scan_ff; keep_in = keep_ff;
      cmd_in = cmd_ff; fidx_in = fidx_ff; sub_in = sub_ff; done_in = done_ff;
      valid_in = 1'b0;
      stat_in = stat_ff; aidx_in = aidx_ff; grew_in = grew_ff;
      rs_we = 1'b0; rs_wa = top_ff[AW-1:0]; rs_wd = pi_rd;
      rs_ra = AW'(top_ff - PW'(1));
      pi_we = 1'b0; pi_wa = fill_ff[AW-1:0]; pi_wd = fidx_ff; ps_wd = sub_ff;
      pi_ra = scan_ff[AW-1:0];

      if (csr_wr && paddr[1:0] == 2'b00) begin
         if (paddr[2] == REG_INIT_CAP) icap_in = pwdata[CNT_W-1:0];
         else                          mcap_in = pwdata[CNT_W-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = req_cmd; fidx_in = req_free_index;
               sub_in = req_submitted_fence; done_in = req_completed_fence;
               scan_in = '0; keep_in = '0;
               stat_in = ST_OK; aidx_in = '0; grew_in = 1'b0;
               state_in = (req_cmd == CMD_ALLOC) ? S_RD : S_DONE;
            end
         end
         S_RD: begin
            // address pending[scan]; data lands next cycle
            state_in = (scan_ff < fill_ff) ? S_CMP : S_POP_RD;
         end
         S_CMP: begin
            if (ps_rd <= done_ff) begin
               if (top_ff < DEPTH_C) begin
                  rs_we = 1'b1; top_in = top_ff + PW'(1);
               end
            end else begin
               pi_we = 1'b1; pi_wa = keep_ff[AW-1:0];
               pi_wd = pi_rd; ps_wd = ps_rd;
               keep_in = keep_ff + PW'(1);
            end
            scan_in = scan_ff + PW'(1);
            state_in = S_RD;
         end
         S_POP_RD: begin
            fill_in = keep_ff;
            state_in = S_POP;
         end
         S_POP: begin
            if (top_ff != '0) begin
               top_in = top_ff - PW'(1);
               aidx_in = rs_rd;
               if (live_ff != CNT_MAX) live_in = live_ff + CNT_W'(1);
            end else if (cur_c >= cap_ff && cap_ff >= eff_max) begin
               stat_in = ST_EXHAUST;
            end else begin
               if (cur_c >= cap_ff) begin
                  cap_in = (cap_ff > (eff_max >> 1)) ? eff_max : (cap_ff << 1);
                  if (grow_ff != GROW_MAX) grow_in = grow_ff + GROW_W'(1);
                  grew_in = 1'b1;
               end
               aidx_in = IDX_W'(cur_ff);
               cur_in = cur_ff + PW'(1);
               if (live_ff != CNT_MAX) live_in = live_ff + CNT_W'(1);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (cmd_ff == CMD_FREE) begin
               if ({{(PW > IDX_W ? PW-IDX_W : 0){1'b0}}, fidx_ff} >= PW'(cur_ff)) begin
                  stat_in = ST_IGNORED;
               end else if ((top_ff + fill_ff) >= DEPTH_C) begin
                  stat_in = ST_DROPPED;
               end else begin
                  if (live_ff != '0) live_in = live_ff - CNT_W'(1);
                  pi_we = 1'b1;
                  fill_in = fill_ff + PW'(1);
               end
            end else if (cmd_ff == CMD_INIT) begin
               cap_in = eff_init;
               top_in = '0; fill_in = '0; cur_in = '0;
               live_in = '0; peak_in = '0; grow_in = '0;
            end else if (cmd_ff == CMD_ALLOC) begin
               if (live_ff > peak_ff) peak_in = live_ff;
            end
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         icap_ff <= INIT_CAP_RESET; mcap_ff <= MAX_CAP_RESET;
         cap_ff <= INIT_CAP_RESET;
         live_ff <= '0; peak_ff <= '0; grow_ff <= '0;
         top_ff <= '0; fill_ff <= '0; cur_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         icap_ff <= icap_in; mcap_ff <= mcap_in;
         cap_ff <= cap_in; live_ff <= live_in; peak_ff <= peak_in;
         grow_ff <= grow_in;
         top_ff <= top_in; fill_ff <= fill_in; cur_ff <= cur_in;
         valid_ff <= valid_in;
      end
      scan_ff <= scan_in; keep_ff <= keep_in;
      cmd_ff <= cmd_in; fidx_ff <= fidx_in; sub_ff <= sub_in; done_ff <= done_in;
      stat_ff <= stat_in; aidx_ff <= aidx_in; grew_ff <= grew_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = valid_ff;
   assign rsp_status        = stat_ff;
   assign rsp_alloc_index   = aidx_ff;
   assign rsp_grew          = grew_ff;
   assign rsp_capacity_now  = cap_ff;
   assign rsp_live_count    = live_ff;
   assign rsp_peak_live     = peak_ff;
   assign rsp_ready_count   = CNT_W'(top_ff);
   assign rsp_pending_count = CNT_W'(fill_ff);
   assign rsp_growth_count  = grow_ff;

`ifndef SYNTHESIS
   // during a reclaim the stack grows before the pending fill is trimmed
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> ({1'b0, top_ff} + {1'b0, fill_ff}) <= {1'b0, DEPTH_C})
      else $error("lists exceed store");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> peak_ff >= live_ff || cmd_ff == CMD_FREE)
      else $error("peak below live");
`endif
endmodule

@@ tb/sv/fence_deferred_index_allocator_unit_tb.sv @@
// Self-checking testbench for the fence-deferred index allocator unit.
module fence_deferred_index_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fdia_pkg::*;

   localparam int DEPTH      = 1024;
   localparam int FB         = 48;
   localparam int CYCLE_CAP  = 3000000;
   localparam logic [2:0] ADDR_INIT_CAP = {REG_INIT_CAP, 2'b00};
   localparam logic [2:0] ADDR_MAX_CAP  = {REG_MAX_CAP, 2'b00};

   typedef struct packed {
      logic [1:0]        status;
      logic [IDX_W-1:0]  index;
      logic              grew;
      logic [CNT_W-1:0]  capacity;
      logic [CNT_W-1:0]  live;
      logic [CNT_W-1:0]  peak;
      logic [CNT_W-1:0]  ready;
      logic [CNT_W-1:0]  pending;
      logic [GROW_W-1:0] growth;
   } alloc_result_type;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic [FB-1:0]    stamp;
   } parked_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]       req_cmd = CMD_ALLOC;
   logic [IDX_W-1:0] req_free_index = '0;
   logic [FB-1:0]    req_submitted_fence = '0;
   logic [FB-1:0]    req_completed_fence = '0;
   logic rsp_valid;
   logic [1:0]        rsp_status;
   logic [IDX_W-1:0]  rsp_alloc_index;
   logic              rsp_grew;
   logic [CNT_W-1:0]  rsp_capacity_now, rsp_live_count, rsp_peak_live;
   logic [CNT_W-1:0]  rsp_ready_count, rsp_pending_count;
   logic [GROW_W-1:0] rsp_growth_count;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   fence_deferred_index_allocator_unit #(.STORE_DEPTH(DEPTH), .FENCE_BITS(FB)) u_dut (
      .clock, .reset, .start, .busy,
      .req_cmd, .req_free_index, .req_submitted_fence, .req_completed_fence,
      .rsp_valid, .rsp_status, .rsp_alloc_index, .rsp_grew, .rsp_capacity_now,
      .rsp_live_count, .rsp_peak_live, .rsp_ready_count, .rsp_pending_count,
      .rsp_growth_count, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #1 clock = ~clock;

   // predictor state
   int unsigned   init_cap_cfg, max_cap_cfg;
   logic [IDX_W-1:0] free_stack[$];
   parked_type    parked[$];
   int unsigned   cursor, capacity, live, peak, growth;
   alloc_result_type expected_q[$];
   int unsigned   errors, beats_seen, items_sent, cycles;
   int unsigned   n_alloc, n_free, n_grew, n_exhaust, n_ignored, n_dropped;
   logic [IDX_W-1:0] handed_out[$];
   logic [FB-1:0] sub_fence;
   bit            allow_gaps;

   function automatic int unsigned eff_max_cap();
      int unsigned m;
      m = (max_cap_cfg == 0) ? 1 : max_cap_cfg;
      return (m > DEPTH) ? DEPTH : m;
   endfunction

   function automatic void pool_init();
      int unsigned c;
      c = (init_cap_cfg == 0) ? 1 : init_cap_cfg;
      capacity = (c < eff_max_cap()) ? c : eff_max_cap();
      free_stack.delete();
      parked.delete();
      cursor = 0;
      live = 0;
      peak = 0;
      growth = 0;
   endfunction

   function automatic alloc_result_type predict_step(logic [1:0] cmd, logic [IDX_W-1:0] fidx,
                                                     logic [FB-1:0] sub, logic [FB-1:0] done);
      alloc_result_type r;
      parked_type kept[$];
      int unsigned m;
      bit ok;
      r = '0;
      case (cmd)
         CMD_ALLOC: begin
            ok = 1'b1;
            foreach (parked[i]) begin
               if (parked[i].stamp <= done) begin
                  if (free_stack.size() < DEPTH)
                     free_stack.insert(free_stack.size(), parked[i].index);
               end else begin
                  kept.insert(kept.size(), parked[i]);
               end
            end
            parked = kept;
            if (free_stack.size() > 0) begin
               r.index = free_stack[$];
               free_stack.delete(free_stack.size() - 1);
            end else begin
               if (cursor >= capacity) begin
                  m = eff_max_cap();
                  if (capacity >= m) begin
                     ok = 1'b0;
                  end else begin
                     capacity = (capacity > m / 2) ? m : capacity * 2;
                     if (growth < 15) growth++;
                     r.grew = 1'b1;
                  end
               end
               if (ok) begin
                  r.index = IDX_W'(cursor);
                  cursor++;
               end
            end
            if (ok) begin
               if (live < 2047) live++;
               if (live > peak) peak = live;
            end else begin
               r.status = ST_EXHAUST;
               r.index = '0;
            end
         end
         CMD_FREE: begin
            if (fidx >= cursor) begin
               r.status = ST_IGNORED;
            end else if (free_stack.size() + parked.size() >= DEPTH) begin
               r.status = ST_DROPPED;
            end else begin
               if (live > 0) live--;
               parked.insert(parked.size(), parked_type'{index: fidx, stamp: sub});
            end
         end
         CMD_INIT: pool_init();
         default: ;
      endcase
      r.capacity = CNT_W'(capacity);
      r.live     = CNT_W'(live);
      r.peak     = CNT_W'(peak);
      r.ready    = CNT_W'(free_stack.size());
      r.pending  = CNT_W'(parked.size());
      r.growth   = GROW_W'(growth);
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      alloc_result_type exp_r, got;
      if (!reset && rsp_valid) begin
         got = '{rsp_status, rsp_alloc_index, rsp_grew, rsp_capacity_now, rsp_live_count,
                 rsp_peak_live, rsp_ready_count, rsp_pending_count, rsp_growth_count};
         beats_seen++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat %p", $realtime, got);
         end else begin
            exp_r = expected_q.pop_front();
            if (got.status !== exp_r.status) begin
               errors++;
               $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
            end
            if (got.index !== exp_r.index) begin
               errors++;
               $display("%0t: alloc_index exp %0d got %0d", $realtime, exp_r.index, got.index);
            end
            if (got.grew !== exp_r.grew) begin
               errors++;
               $display("%0t: grew exp %0d got %0d", $realtime, exp_r.grew, got.grew);
            end
            if (got.capacity !== exp_r.capacity) begin
               errors++;
               $display("%0t: capacity exp %0d got %0d", $realtime, exp_r.capacity,
                        got.capacity);
            end
            if (got.live !== exp_r.live) begin
               errors++;
               $display("%0t: live exp %0d got %0d", $realtime, exp_r.live, got.live);
            end
            if (got.peak !== exp_r.peak) begin
               errors++;
               $display("%0t: peak exp %0d got %0d", $realtime, exp_r.peak, got.peak);
            end
            if (got.ready !== exp_r.ready) begin
               errors++;
               $display("%0t: ready exp %0d got %0d", $realtime, exp_r.ready, got.ready);
            end
            if (got.pending !== exp_r.pending) begin
               errors++;
               $display("%0t: pending exp %0d got %0d", $realtime, exp_r.pending,
                        got.pending);
            end
            if (got.growth !== exp_r.growth) begin
               errors++;
               $display("%0t: growth exp %0d got %0d", $realtime, exp_r.growth, got.growth);
            end
         end
      end
   end

   task automatic sender_gap();
      if (allow_gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 17)) @(negedge clock);
   endtask

   // one request beat; start drops again on the next falling edge
   task automatic send_item(logic [1:0] cmd, logic [IDX_W-1:0] fidx,
                            logic [FB-1:0] sub, logic [FB-1:0] done);
      alloc_result_type r;
      sender_gap();
      @(negedge clock);
      start = 1'b1;
      req_cmd = cmd;
      req_free_index = fidx;
      req_submitted_fence = sub;
      req_completed_fence = done;
      do @(posedge clock); while (busy);
      r = predict_step(cmd, fidx, sub, done);
      expected_q.insert(expected_q.size(), r);
      items_sent++;
      case (cmd)
         CMD_ALLOC: begin
            n_alloc++;
            if (r.grew) n_grew++;
            if (r.status == ST_EXHAUST) n_exhaust++;
            else handed_out.insert(handed_out.size(), r.index);
         end
         CMD_FREE: begin
            n_free++;
            if (r.status == ST_IGNORED) n_ignored++;
            if (r.status == ST_DROPPED) n_dropped++;
         end
         default: ;
      endcase
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic drain();
      while (expected_q.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, int unsigned value);
      drain();
      @(negedge clock);
      psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
      if (addr == ADDR_INIT_CAP) init_cap_cfg = value & 32'h7FF;
      else max_cap_cfg = value & 32'h7FF;
      // read back
      paddr = addr;
      psel = 1'b1;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      if (prdata[CNT_W-1:0] !== CNT_W'(value)) begin
         errors++;
         $display("%0t: csr %0d readback exp %0d got %0d", $realtime, addr,
                  value & 32'h7FF, prdata);
      end
      @(negedge clock);
      psel = 1'b0; penable = 1'b0;
   endtask

   task automatic configure(int unsigned init_cap, int unsigned max_cap);
      csr_write(ADDR_MAX_CAP, max_cap);
      csr_write(ADDR_INIT_CAP, init_cap);
      send_item(CMD_INIT, '0, '0, '0);
   endtask

   task automatic test_growth();
      configure(1, 1024);
      repeat (4) send_item(CMD_ALLOC, '0, '0, '0);
      configure(3, 5);   // clamps to the maximum on the first growth
      repeat (7) send_item(CMD_ALLOC, '0, '0, '0);
   endtask

   task automatic test_fence_reclaim();
      configure(8, 8);
      repeat (4) send_item(CMD_ALLOC, '0, '0, '0);
      send_item(CMD_FREE, 10'd9, 48'd1, '0);        // beyond cursor: ignored
      send_item(CMD_FREE, 10'd2, 48'd5, '0);
      send_item(CMD_FREE, 10'd0, '1, '0);
      send_item(CMD_FREE, 10'd3, 48'd4, '0);
      send_item(CMD_ALLOC, '0, '0, 48'd3);          // nothing due yet
      send_item(CMD_ALLOC, '0, '0, 48'd5);          // two due, stack order kept
      send_item(CMD_ALLOC, '0, '1, '1);             // all-ones fence reclaims the rest
      send_item(2'd3, '1, '1, '1);                  // undefined command
   endtask

   task automatic test_store_full();
      configure(1, 1);
      send_item(CMD_ALLOC, '0, '0, '0);
      repeat (DEPTH) send_item(CMD_FREE, '0, '0, '0);
      send_item(CMD_FREE, '0, '0, '0);              // store full: dropped
      send_item(CMD_ALLOC, '0, '0, '0);             // reclaims everything
      send_item(CMD_FREE, '0, '1, '0);
      send_item(CMD_FREE, '0, '1, '0);
      send_item(CMD_INIT, '0, '0, '0);
   endtask

   task automatic test_register_extremes();
      configure(0, 0);
      repeat (3) send_item(CMD_ALLOC, '0, '0, '0);
      configure(2047, 2047);
      repeat (2) send_item(CMD_ALLOC, '0, '0, '0);
   endtask

   function automatic int unsigned pick_cap();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 1;
         2: return 1024;
         3: return 2047;
         default: return $urandom_range(1, 64);
      endcase
   endfunction

   task automatic test_random(int unsigned total);
      int unsigned k, sel, pos, budget;
      logic [IDX_W-1:0] fidx;
      logic [FB-1:0] done;
      k = 0;
      while (k < total) begin
         configure(pick_cap(), pick_cap());
         handed_out.delete();
         budget = $urandom_range(40, 140);
         repeat (budget) begin
            if (k > total * 4 / 5) allow_gaps = 1'b0;
            sel = $urandom_range(0, 99);
            sub_fence += FB'($urandom_range(0, 3));
            done = sub_fence - FB'($urandom_range(0, 6));
            if (parked.size() > 40) done = '1;
            if ($urandom_range(0, 19) == 0) begin
               sub_fence = FB'({$urandom, $urandom});
               done = FB'({$urandom, $urandom});
            end
            if (sel < 45) begin
               send_item(CMD_ALLOC, IDX_W'($urandom), sub_fence, done);
            end else if (sel < 90) begin
               if (sel < 75 && handed_out.size() > 0) begin
                  pos = $urandom_range(0, handed_out.size() - 1);
                  fidx = handed_out[pos];
                  handed_out.delete(pos);
               end else if (sel < 83 && cursor > 0) begin
                  fidx = IDX_W'($urandom_range(0, cursor - 1));
               end else begin
                  fidx = IDX_W'($urandom);
               end
               send_item(CMD_FREE, fidx, sub_fence, done);
            end else if (sel < 95) begin
               send_item(2'd3, IDX_W'($urandom), FB'({$urandom, $urandom}),
                         FB'({$urandom, $urandom}));
            end else begin
               send_item(CMD_INIT, IDX_W'($urandom), sub_fence, done);
               handed_out.delete();
            end
            k++;
         end
      end
   endtask

   initial begin
      init_cap_cfg = INIT_CAP_RESET;
      max_cap_cfg  = MAX_CAP_RESET;
      pool_init();
      sub_fence = '0;
      allow_gaps = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (3) send_item(CMD_ALLOC, '0, '0, '0);   // reset defaults
      test_growth();
      test_fence_reclaim();
      test_register_extremes();
      test_store_full();
      test_random(600);
      drain();
      repeat (40) @(posedge clock);
      $display("Sent %0d items, checked %0d results: %0d allocates (%0d grew, %0d exhausted)",
               items_sent, beats_seen, n_alloc, n_grew, n_exhaust);
      $display("%0d frees (%0d ignored, %0d dropped on a full store)", n_free, n_ignored,
               n_dropped);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

@@ sim.f @@
sv/fdia_pkg.sv
sv/fdia_ram.sv
sv/fence_deferred_index_allocator_unit.sv
tb/sv/fence_deferred_index_allocator_unit_tb.sv
